>>> src/mtb_pkg.sv
// Shared types, constants and word functions for the bounded MT19937 generator.
// No dependencies.
package mtb_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 2);

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx IDX_LAST     = IDX_W'(STATE_WORDS - 1);
    localparam t_idx IDX_SPENT    = IDX_W'(STATE_WORDS);
    localparam t_idx IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);
    localparam t_idx FAR_STEP     = IDX_W'(TWIST_OFFSET);
    localparam t_idx FAR_BACK     = IDX_W'(STATE_WORDS - TWIST_OFFSET);

    localparam t_word DEFAULT_SEED = 32'd4357;
    localparam t_word SEED_MULT    = 32'd69069;
    localparam t_word TWIST_MATRIX = 32'h9908_b0df;
    localparam t_word HIGH_BIT     = 32'h8000_0000;
    localparam t_word LOW_BITS     = 32'h7fff_ffff;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic t_word twist_word(input t_word cur, input t_word nxt, input t_word far);
        t_word y;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
    endfunction

endpackage

>>> src/mtb_ifs.sv
// Valid/ready channel interfaces: request (bound) and response (value).
// Depends on mtb_pkg.
interface mtb_req_if;
    import mtb_pkg::*;
    logic  valid;
    logic  ready;
    t_word bound;
    modport source(output valid, output bound, input ready);
    modport sink(input valid, input bound, output ready);
endinterface

interface mtb_rsp_if;
    import mtb_pkg::*;
    logic  valid;
    logic  ready;
    t_word value;
    modport source(output valid, output value, input ready);
    modport sink(input valid, input value, output ready);
endinterface

>>> src/mtb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mtb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/mtb_mod_unit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on mtb_pkg. Divisor must be nonzero.
module mtb_mod_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mtb_pkg::t_word i_dividend,
    input  mtb_pkg::t_word i_divisor,
    output logic          o_done,
    output mtb_pkg::t_word o_rem
);
    import mtb_pkg::*;

    localparam int STEPS = $bits(t_word);
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_dvd;
    t_word            r_dvs;
    logic [STEPS:0]   shifted;
    logic [STEPS:0]   diff;
    t_word            n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[STEPS-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_rem   = diff[STEPS] ? shifted[STEPS-1:0] : diff[STEPS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

>>> src/mersenne_twister_bounded_rng.sv
// Top level: bounded MT19937 generator, state table in one RAM, sequencer, remainder unit.
// Depends on mtb_pkg, mtb_ifs, mtb_ram, mtb_mod_unit.
//
//   channel   dir  handshake            payload
//   i_req     in   valid/ready          bound [31:0]
//   o_rsp     out  valid/ready          value [31:0]
//   cfg       in   i_cfg_we (no ready)  i_cfg_wdata [31:0] (seed)
//
// Nonzero bound: RAM read, temper, remainder start, 32-step remainder unit,
// handoff, output load; ready returns after the output load. A zero bound
// skips the RAM and the remainder unit and returns 0. Every 624 words add a
// twist, reading on the single RAM read port. A seed write, or the first
// request after reset, refills the table. Reset is synchronous and marks the
// table unseeded. A finished result waits in the output register, so the next
// transaction is taken while the response is stalled.
module mersenne_twister_bounded_rng (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  mtb_pkg::t_word i_cfg_wdata,
    mtb_req_if.sink        i_req,
    mtb_rsp_if.source      o_rsp
);
    import mtb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_TW_INIT,
        S_TW_LOAD,
        S_TW_FAR,
        S_TW_WR,
        S_READ,
        S_TEMPER,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_idx   r_index;
    t_idx   r_k;
    t_word  r_fill_word;
    t_word  r_cur;
    t_word  r_nxt;
    t_word  r_bound;
    t_word  r_word;
    t_word  r_res;
    t_word  r_seed;
    logic   r_item;
    logic   r_cfg_pend;
    logic   r_div_start;
    logic   r_out_valid;
    t_word  r_out_value;

    t_word  n_fill_word;
    t_idx   k_nxt;
    t_idx   k_far;
    t_idx   k1_nxt;
    t_word  cfg_seed;
    logic   cfg_go;
    logic   req_acc;
    logic   out_free;
    logic   fill_start;

    logic   ram_we;
    t_idx   ram_waddr;
    t_word  ram_wdata;
    t_idx   ram_raddr;
    t_word  ram_rdata;
    logic   div_done;
    t_word  div_rem;

    mtb_ram #(
        .WIDTH($bits(t_word)),
        .DEPTH(STATE_WORDS)
    ) u_mtb_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mtb_mod_unit u_mtb_mod_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(r_word),
        .i_divisor (r_bound),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign cfg_go      = i_cfg_we || r_cfg_pend;
    assign cfg_seed    = i_cfg_we ? i_cfg_wdata : r_seed;
    assign n_fill_word = t_word'(r_fill_word * SEED_MULT);
    assign fill_start  = cfg_go && (((r_state == S_IDLE) && !req_acc) ||
                                    ((r_state == S_DONE) && out_free) ||
                                    ((r_state == S_FILL) && i_cfg_we));

    // twist neighbors of word k, and the next-neighbor of word k+1
    always_comb begin
        k_nxt  = (r_k == IDX_LAST) ? '0 : r_k + t_idx'(1);
        k_far  = (r_k < FAR_BACK) ? r_k + FAR_STEP : r_k - FAR_BACK;
        k1_nxt = (k_nxt == IDX_LAST) ? '0 : k_nxt + t_idx'(1);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = r_fill_word;
        ram_raddr = r_index;
        case (r_state)
            S_FILL: begin
                ram_we = 1'b1;
            end
            S_TW_INIT: begin
                ram_raddr = '0;
            end
            S_TW_LOAD: begin
                ram_raddr = k_nxt;
            end
            S_TW_FAR: begin
                ram_raddr = k_far;
            end
            S_TW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = twist_word(r_cur, r_nxt, ram_rdata);
                ram_raddr = k1_nxt;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_index     <= IDX_UNSEEDED;
            r_item      <= 1'b0;
            r_cfg_pend  <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_bound <= i_req.bound;
                        if (i_req.bound == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (r_index == IDX_UNSEEDED) begin
                            r_item      <= 1'b1;
                            r_fill_word <= DEFAULT_SEED;
                            r_k         <= '0;
                            r_state     <= S_FILL;
                        end else if (r_index == IDX_SPENT) begin
                            r_state <= S_TW_INIT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_FILL: begin
                    r_fill_word <= n_fill_word;
                    r_k         <= r_k + t_idx'(1);
                    if (r_k == IDX_LAST) begin
                        r_index <= IDX_SPENT;
                        r_item  <= 1'b0;
                        r_state <= r_item ? S_TW_INIT : S_IDLE;
                    end
                end
                S_TW_INIT: begin
                    r_k     <= '0;
                    r_state <= S_TW_LOAD;
                end
                S_TW_LOAD: begin
                    r_cur   <= ram_rdata;
                    r_state <= S_TW_FAR;
                end
                S_TW_FAR: begin
                    r_nxt   <= ram_rdata;
                    r_state <= S_TW_WR;
                end
                S_TW_WR: begin
                    r_cur <= r_nxt;
                    r_k   <= k_nxt;
                    if (r_k == IDX_LAST) begin
                        r_index <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_TW_FAR;
                    end
                end
                S_READ: begin
                    r_state <= S_TEMPER;
                end
                S_TEMPER: begin
                    r_word      <= temper(ram_rdata);
                    r_index     <= r_index + t_idx'(1);
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_res   <= div_rem;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // seed write refills when idle or as a result is handed off, or restarts a fill in progress
            if (fill_start) begin
                r_fill_word <= cfg_seed;
                r_k         <= '0;
                r_cfg_pend  <= 1'b0;
                r_state     <= S_FILL;
            end else if (i_cfg_we) begin
                r_cfg_pend <= 1'b1;
            end
        end
    end
endmodule

>>> src/mtb_checker.sv
// Port-level checks for the bounded MT19937 generator, bound to the top level.
// Depends on mersenne_twister_bounded_rng and its interfaces.
module mtb_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [31:0] i_req_bound,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_value
);
    logic [1:0]  r_cnt;
    logic [31:0] r_last_bound;
    logic        req_acc;
    logic        rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
        if (req_acc) begin
            r_last_bound <= i_req_bound;
        end
    end

    a_no_orphan_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_cnt != 2'd0)
        else $error("response without an outstanding transaction");

    a_max_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two transactions outstanding");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && r_cnt == 2'd1) |->
            ((r_last_bound == 32'd0 && i_rsp_value == 32'd0) ||
             (r_last_bound != 32'd0 && i_rsp_value < r_last_bound)))
        else $error("response value not below its bound");

    a_seed_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_req_ready)
        else $error("request accepted while table refills");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_value)))
        else $error("stalled response changed");
endmodule

bind mersenne_twister_bounded_rng mtb_port_checks u_mtb_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_req_bound(i_req.bound),
    .i_rsp_valid(o_rsp.valid),
    .i_rsp_ready(o_rsp.ready),
    .i_rsp_value(o_rsp.value)
);
